// ===== hw/rtl/swbg_pkg.sv =====
`default_nettype none

package swbg_pkg;

  // Bin store geometry
  localparam int BIN_DEPTH = 256;
  localparam int BIN_AW    = $clog2(BIN_DEPTH);
  localparam int BIN_W     = 8;

  // Field widths
  localparam int SMP_W  = 24;
  localparam int FRAC_W = 16;
  localparam int COEF_W = FRAC_W;
  localparam int ONE_W  = FRAC_W + 1;
  localparam int PRES_W = 17;
  localparam int GAIN_W = FRAC_W + 1;
  localparam int CFG_W  = 17;

  // Datapath widths
  localparam int POW_W     = 48;
  localparam int PROD_W    = 64;
  localparam int DEN_W     = POW_W + 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int DIV_STEPS = GAIN_W;
  localparam int SCL_W     = GAIN_W + SMP_W;

  // Result queue and request credits
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = FIFO_AW + 1;

  localparam logic [ONE_W-1:0] COEF_ONE   = ONE_W'(1) << FRAC_W;
  localparam logic [SCL_W-1:0] ROUND_HALF = SCL_W'(1) << (FRAC_W - 1);

  // Register reset values
  localparam logic [PRES_W-1:0] SPP_THR_RST  = PRES_W'(32768);
  localparam logic [COEF_W-1:0] NOISE_A_RST  = COEF_W'(58982);
  localparam logic [COEF_W-1:0] SPEECH_A_RST = COEF_W'(64225);
  localparam logic [COEF_W-1:0] FLOOR_RST    = COEF_W'(207);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPP_THRESHOLD    = 2'd0,
    CFG_NOISE_SMOOTHING  = 2'd1,
    CFG_SPEECH_SMOOTHING = 2'd2,
    CFG_SPEECH_FLOOR     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PRES_W-1:0] spp_thr;
    logic [COEF_W-1:0] noise_a;
    logic [COEF_W-1:0] speech_a;
    logic [COEF_W-1:0] floor_xi;
  } cfg_t;

  typedef struct packed {
    logic [BIN_AW-1:0] bin;
    logic [SMP_W-1:0]  re;
    logic [SMP_W-1:0]  im;
  } item_t;

  typedef struct packed {
    item_t             itm;
    logic [POW_W-1:0]  s;
    logic [DEN_W-1:0]  den;
    logic              zero;
  } div_in_t;

  typedef struct packed {
    item_t             itm;
    logic [GAIN_W-1:0] quo;
    logic              zero;
  } div_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [SMP_W-1:0]  re;
    logic [SMP_W-1:0]  im;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swbg_state_mem.sv =====
`default_nettype none

module swbg_state_mem (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [swbg_pkg::BIN_AW-1:0]         rd_addr_i,
  output logic [swbg_pkg::POW_W-1:0]          rd_data_o,
  input  logic                                wr_en_i,
  input  logic [swbg_pkg::BIN_AW-1:0]         wr_addr_i,
  input  logic [swbg_pkg::POW_W-1:0]          wr_data_i
);

  logic [swbg_pkg::POW_W-1:0]     mem_q [swbg_pkg::BIN_DEPTH];
  logic [swbg_pkg::POW_W-1:0]     rd_data_q;
  logic [swbg_pkg::BIN_DEPTH-1:0] written_q;
  logic                           rd_hit_q;

  // Storage array, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/swbg_est.sv =====
`default_nettype none

module swbg_est (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_vld_i,
  input  swbg_pkg::item_t                 in_itm_i,
  input  logic [swbg_pkg::PRES_W-1:0]     in_pres_i,
  input  logic [swbg_pkg::POW_W-1:0]      noise_i,
  input  logic [swbg_pkg::POW_W-1:0]      prev_i,
  input  swbg_pkg::cfg_t                  cfg_i,
  output logic                            nw_en_o,
  output logic [swbg_pkg::BIN_AW-1:0]     nw_addr_o,
  output logic [swbg_pkg::POW_W-1:0]      nw_data_o,
  output logic                            out_vld_o,
  output swbg_pkg::div_in_t               out_o
);

  localparam int POW_W  = swbg_pkg::POW_W;
  localparam int PROD_W = swbg_pkg::PROD_W;
  localparam int FRAC_W = swbg_pkg::FRAC_W;
  localparam int DEN_W  = swbg_pkg::DEN_W;
  localparam int ONE_W  = swbg_pkg::ONE_W;

  // Complement weights (1 - a)
  logic [ONE_W-1:0] wan_w, was_w;
  assign wan_w = swbg_pkg::COEF_ONE - ONE_W'(cfg_i.noise_a);
  assign was_w = swbg_pkg::COEF_ONE - ONE_W'(cfg_i.speech_a);

  // Stage B: squares and weighted old state
  logic signed [POW_W-1:0] sqr_w, sqi_w;
  logic [PROD_W-1:0]       an_w, as_w;
  assign sqr_w = $signed(in_itm_i.re) * $signed(in_itm_i.re);
  assign sqi_w = $signed(in_itm_i.im) * $signed(in_itm_i.im);
  assign an_w  = PROD_W'(cfg_i.noise_a) * PROD_W'(noise_i);
  assign as_w  = PROD_W'(cfg_i.speech_a) * PROD_W'(prev_i);

  logic                 b_vld_q;
  swbg_pkg::item_t      b_itm_q;
  logic [POW_W-1:0]     b_sqr_q, b_sqi_q, b_n_q;
  logic [PROD_W-1:0]    b_an_q, b_as_q;
  logic                 b_gate_q;

  always_ff @(posedge clk_i) begin
    b_itm_q  <= in_itm_i;
    b_sqr_q  <= sqr_w;
    b_sqi_q  <= sqi_w;
    b_an_q   <= an_w;
    b_as_q   <= as_w;
    b_n_q    <= noise_i;
    b_gate_q <= in_pres_i < cfg_i.spp_thr;
  end

  // Stage C: |Y|^2
  logic                 c_vld_q;
  swbg_pkg::item_t      c_itm_q;
  logic [POW_W-1:0]     c_y2_q, c_n_q;
  logic [PROD_W-1:0]    c_an_q, c_as_q;
  logic                 c_gate_q;

  always_ff @(posedge clk_i) begin
    c_itm_q  <= b_itm_q;
    c_y2_q   <= b_sqr_q + b_sqi_q;
    c_n_q    <= b_n_q;
    c_an_q   <= b_an_q;
    c_as_q   <= b_as_q;
    c_gate_q <= b_gate_q;
  end

  // Stage D: weighted |Y|^2 terms
  logic                 d_vld_q;
  swbg_pkg::item_t      d_itm_q;
  logic [POW_W-1:0]     d_n_q;
  logic [PROD_W-1:0]    d_an_q, d_as_q, d_ny_q, d_sy_q;
  logic                 d_gate_q;

  always_ff @(posedge clk_i) begin
    d_itm_q  <= c_itm_q;
    d_n_q    <= c_n_q;
    d_an_q   <= c_an_q;
    d_as_q   <= c_as_q;
    d_ny_q   <= PROD_W'(wan_w) * PROD_W'(c_y2_q);
    d_sy_q   <= PROD_W'(was_w) * PROD_W'(c_y2_q);
    d_gate_q <= c_gate_q;
  end

  // Stage E: gated noise update, positive DD term
  logic [PROD_W-1:0] nsum_w;
  assign nsum_w = d_an_q + d_ny_q;

  logic                 e_vld_q;
  swbg_pkg::item_t      e_itm_q;
  logic [POW_W-1:0]     e_n_q;
  logic [PROD_W-1:0]    e_pos_q;

  always_ff @(posedge clk_i) begin
    e_itm_q <= d_itm_q;
    e_n_q   <= d_gate_q ? nsum_w[FRAC_W +: POW_W] : d_n_q;
    e_pos_q <= d_as_q + d_sy_q;
  end

  assign nw_en_o   = e_vld_q;
  assign nw_addr_o = e_itm_q.bin;
  assign nw_data_o = e_n_q;

  // Stage F: negative DD term and floor
  logic [PROD_W-1:0] flp_w;
  assign flp_w = PROD_W'(cfg_i.floor_xi) * PROD_W'(e_n_q);

  logic                 f_vld_q;
  swbg_pkg::item_t      f_itm_q;
  logic [POW_W-1:0]     f_n_q, f_fl_q;
  logic [PROD_W-1:0]    f_pos_q, f_neg_q;

  always_ff @(posedge clk_i) begin
    f_itm_q <= e_itm_q;
    f_n_q   <= e_n_q;
    f_pos_q <= e_pos_q;
    f_neg_q <= PROD_W'(was_w) * PROD_W'(e_n_q);
    f_fl_q  <= flp_w[FRAC_W +: POW_W];
  end

  // Stage G: DD estimate, clipped at zero
  logic [PROD_W-1:0] diff_w;
  assign diff_w = f_pos_q - f_neg_q;

  logic                 g_vld_q;
  swbg_pkg::item_t      g_itm_q;
  logic [POW_W-1:0]     g_n_q, g_fl_q, g_sdd_q;

  always_ff @(posedge clk_i) begin
    g_itm_q <= f_itm_q;
    g_n_q   <= f_n_q;
    g_fl_q  <= f_fl_q;
    g_sdd_q <= (f_pos_q > f_neg_q) ? diff_w[FRAC_W +: POW_W] : '0;
  end

  // Stage H: apply floor
  logic                 h_vld_q;
  swbg_pkg::item_t      h_itm_q;
  logic [POW_W-1:0]     h_n_q, h_s_q;

  always_ff @(posedge clk_i) begin
    h_itm_q <= g_itm_q;
    h_n_q   <= g_n_q;
    h_s_q   <= (g_sdd_q > g_fl_q) ? g_sdd_q : g_fl_q;
  end

  // Stage I: denominator S + N
  swbg_pkg::div_in_t i_q;
  logic              i_vld_q;

  always_ff @(posedge clk_i) begin
    i_q <= '{itm:  h_itm_q,
             s:    h_s_q,
             den:  DEN_W'(h_s_q) + DEN_W'(h_n_q),
             zero: (h_s_q == '0) && (h_n_q == '0)};
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else begin
      b_vld_q <= in_vld_i;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  assign out_vld_o = i_vld_q;
  assign out_o     = i_q;

endmodule

`default_nettype wire

// ===== hw/rtl/swbg_div.sv =====
`default_nettype none

module swbg_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_vld_i,
  input  swbg_pkg::div_in_t      in_i,
  output logic                   out_vld_o,
  output swbg_pkg::div_out_t     out_o
);

  localparam int STEPS  = swbg_pkg::DIV_STEPS;
  localparam int REM_W  = swbg_pkg::REM_W;
  localparam int GAIN_W = swbg_pkg::GAIN_W;
  localparam int DEN_W  = swbg_pkg::DEN_W;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [GAIN_W-1:0] quo;
    logic [DEN_W-1:0]  den;
    logic              zero;
    swbg_pkg::item_t   itm;
  } stg_t;

  stg_t             stg_q [STEPS];
  stg_t             src_w [STEPS];
  stg_t             nxt_w [STEPS];
  logic [STEPS-1:0] fit_w;
  logic [STEPS-1:0] vld_q;

  // One restoring quotient bit per stage, MSB first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign src_w[k] = '{rem: REM_W'(in_i.s), quo: '0, den: in_i.den,
                          zero: in_i.zero, itm: in_i.itm};
    end else begin : g_next
      assign src_w[k] = '{rem: {stg_q[k-1].rem[REM_W-2:0], 1'b0},
                          quo: stg_q[k-1].quo, den: stg_q[k-1].den,
                          zero: stg_q[k-1].zero, itm: stg_q[k-1].itm};
    end

    assign fit_w[k] = src_w[k].rem >= REM_W'(src_w[k].den);

    assign nxt_w[k] = '{rem: fit_w[k] ? (src_w[k].rem - REM_W'(src_w[k].den))
                                      : src_w[k].rem,
                        quo: {src_w[k].quo[GAIN_W-2:0], fit_w[k]},
                        den: src_w[k].den, zero: src_w[k].zero, itm: src_w[k].itm};

    always_ff @(posedge clk_i) begin
      stg_q[k] <= nxt_w[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STEPS-2:0], in_vld_i};
    end
  end

  assign out_vld_o  = vld_q[STEPS-1];
  assign out_o.itm  = stg_q[STEPS-1].itm;
  assign out_o.quo  = stg_q[STEPS-1].quo;
  assign out_o.zero = stg_q[STEPS-1].zero;

endmodule

`default_nettype wire

// ===== hw/rtl/swbg_out_fifo.sv =====
`default_nettype none

module swbg_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  swbg_pkg::res_t   push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output swbg_pkg::res_t   data_o
);

  localparam int AW = swbg_pkg::FIFO_AW;
  localparam int CW = swbg_pkg::CREDIT_W;

  swbg_pkg::res_t  mem_q [swbg_pkg::FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/spp_gated_wiener_bin_gain_core.sv =====
// Speech-presence gated Wiener gain, one STFT bin per request.
//
// Input channel (in_valid_i / in_stall_o): a bin index, the complex noisy bin
// and its speech presence. Output channel (out_valid_o / out_stall_i): the
// Q1.16 gain and the scaled bin, in request order, one per request.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i.
//
// Throughput is one request per cycle while in_stall_o is low. Per-bin noise
// and clean power live in two 256-entry RAMs, read at accept; noise is
// written back from the estimate pipeline and clean power after the scale
// stage. A request whose bin is still in flight is stalled until its clean
// power write-back. The gain divider is a 17-stage pipelined restoring
// divider.
//
// Up to 32 requests are in flight or queued. When the receiver stalls,
// results collect in a 32-entry output queue and the input keeps taking
// requests until that credit is used up.
// Reset clears all per-bin state (valid bits, no clearing pass), restores
// register defaults and empties the pipeline and queue.
`default_nettype none

module spp_gated_wiener_bin_gain_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [swbg_pkg::BIN_W-1:0]      bin_index_i,
  input  logic signed [swbg_pkg::SMP_W-1:0]      bin_real_i,
  input  logic signed [swbg_pkg::SMP_W-1:0]      bin_imag_i,
  input  logic        [swbg_pkg::PRES_W-1:0]     presence_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [swbg_pkg::GAIN_W-1:0]     gain_o,
  output logic signed [swbg_pkg::SMP_W-1:0]      clean_real_o,
  output logic signed [swbg_pkg::SMP_W-1:0]      clean_imag_o,
  input  logic                                   cfg_we_i,
  input  logic        [swbg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [swbg_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int BIN_AW   = swbg_pkg::BIN_AW;
  localparam int SMP_W    = swbg_pkg::SMP_W;
  localparam int POW_W    = swbg_pkg::POW_W;
  localparam int GAIN_W   = swbg_pkg::GAIN_W;
  localparam int SCL_W    = swbg_pkg::SCL_W;
  localparam int FRAC_W   = swbg_pkg::FRAC_W;
  localparam int CREDIT_W = swbg_pkg::CREDIT_W;
  localparam int COEF_W   = swbg_pkg::COEF_W;

  // Configuration registers
  swbg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{spp_thr:  swbg_pkg::SPP_THR_RST,
                 noise_a:  swbg_pkg::NOISE_A_RST,
                 speech_a: swbg_pkg::SPEECH_A_RST,
                 floor_xi: swbg_pkg::FLOOR_RST};
    end else if (cfg_we_i) begin
      case (swbg_pkg::cfg_idx_e'(cfg_idx_i))
        swbg_pkg::CFG_SPP_THRESHOLD:    cfg_q.spp_thr  <= cfg_wdata_i;
        swbg_pkg::CFG_NOISE_SMOOTHING:  cfg_q.noise_a  <= cfg_wdata_i[COEF_W-1:0];
        swbg_pkg::CFG_SPEECH_SMOOTHING: cfg_q.speech_a <= cfg_wdata_i[COEF_W-1:0];
        swbg_pkg::CFG_SPEECH_FLOOR:     cfg_q.floor_xi <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept control: bin interlock and output credits
  logic [BIN_AW-1:0]              bin_addr_w;
  logic [swbg_pkg::BIN_DEPTH-1:0] busy_q, busy_d;
  logic [CREDIT_W-1:0]            credit_q;
  logic                           in_acc_w;
  logic                           out_pop_w;
  logic                           sq_vld_q;
  logic [BIN_AW-1:0]              sq_bin_q;

  assign bin_addr_w = bin_index_i[BIN_AW-1:0];
  assign in_stall_o = busy_q[bin_addr_w] ||
                      (credit_q == CREDIT_W'(swbg_pkg::FIFO_DEPTH));
  assign in_acc_w   = in_valid_i && !in_stall_o;
  assign out_pop_w  = out_valid_o && !out_stall_i;

  // Mark a bin busy at accept, free it at clean power write-back
  always_comb begin
    busy_d = busy_q;
    if (in_acc_w) begin
      busy_d[bin_addr_w] = 1'b1;
    end
    if (sq_vld_q) begin
      busy_d[sq_bin_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      credit_q <= '0;
    end else begin
      busy_q <= busy_d;
      case ({in_acc_w, out_pop_w})
        2'b10:   credit_q <= credit_q + CREDIT_W'(1);
        2'b01:   credit_q <= credit_q - CREDIT_W'(1);
        default: credit_q <= credit_q;
      endcase
    end
  end

  // Request register, aligned with the RAM read
  logic                         a_vld_q;
  swbg_pkg::item_t              a_itm_q;
  logic [swbg_pkg::PRES_W-1:0]  a_pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_acc_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_w) begin
      a_itm_q  <= '{bin: bin_addr_w, re: bin_real_i, im: bin_imag_i};
      a_pres_q <= presence_i;
    end
  end

  // Per-bin state RAMs
  logic [POW_W-1:0]  noise_rd_w, prev_rd_w, prev_wr_w;
  logic              nw_en_w;
  logic [BIN_AW-1:0] nw_addr_w;
  logic [POW_W-1:0]  nw_data_w;
  logic [POW_W-1:0]  sq_r_q, sq_i_q;

  swbg_state_mem u_noise_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc_w),
    .rd_addr_i (bin_addr_w),
    .rd_data_o (noise_rd_w),
    .wr_en_i   (nw_en_w),
    .wr_addr_i (nw_addr_w),
    .wr_data_i (nw_data_w)
  );

  assign prev_wr_w = sq_r_q + sq_i_q;

  swbg_state_mem u_prev_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc_w),
    .rd_addr_i (bin_addr_w),
    .rd_data_o (prev_rd_w),
    .wr_en_i   (sq_vld_q),
    .wr_addr_i (sq_bin_q),
    .wr_data_i (prev_wr_w)
  );

  // Noise update and speech estimate
  logic              est_vld_w;
  swbg_pkg::div_in_t est_w;

  swbg_est u_est (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (a_vld_q),
    .in_itm_i  (a_itm_q),
    .in_pres_i (a_pres_q),
    .noise_i   (noise_rd_w),
    .prev_i    (prev_rd_w),
    .cfg_i     (cfg_q),
    .nw_en_o   (nw_en_w),
    .nw_addr_o (nw_addr_w),
    .nw_data_o (nw_data_w),
    .out_vld_o (est_vld_w),
    .out_o     (est_w)
  );

  // Gain = S / (S + N) in Q1.16
  logic               dv_vld_w;
  swbg_pkg::div_out_t dv_w;

  swbg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (est_vld_w),
    .in_i      (est_w),
    .out_vld_o (dv_vld_w),
    .out_o     (dv_w)
  );

  // Scale stage: gain times bin magnitude
  logic [GAIN_W-1:0] gain_w;
  logic [SMP_W-1:0]  mag_re_w, mag_im_w;

  assign gain_w   = dv_w.zero ? '0 : dv_w.quo;
  assign mag_re_w = dv_w.itm.re[SMP_W-1] ? (SMP_W'(0) - dv_w.itm.re) : dv_w.itm.re;
  assign mag_im_w = dv_w.itm.im[SMP_W-1] ? (SMP_W'(0) - dv_w.itm.im) : dv_w.itm.im;

  logic              sc_vld_q;
  logic [BIN_AW-1:0] sc_bin_q;
  logic [GAIN_W-1:0] sc_gain_q;
  logic [SCL_W-1:0]  sc_pr_q, sc_pi_q;
  logic              sc_nr_q, sc_ni_q;

  always_ff @(posedge clk_i) begin
    sc_bin_q  <= dv_w.itm.bin;
    sc_gain_q <= gain_w;
    sc_pr_q   <= SCL_W'(gain_w) * SCL_W'(mag_re_w);
    sc_pi_q   <= SCL_W'(gain_w) * SCL_W'(mag_im_w);
    sc_nr_q   <= dv_w.itm.re[SMP_W-1];
    sc_ni_q   <= dv_w.itm.im[SMP_W-1];
  end

  // Round half away from zero, restore sign
  logic [SCL_W-1:0] rnd_r_w, rnd_i_w;
  logic [SMP_W-1:0] cr_w, ci_w;
  swbg_pkg::res_t   res_w;

  assign rnd_r_w = sc_pr_q + swbg_pkg::ROUND_HALF;
  assign rnd_i_w = sc_pi_q + swbg_pkg::ROUND_HALF;
  assign cr_w    = sc_nr_q ? (SMP_W'(0) - rnd_r_w[FRAC_W +: SMP_W]) : rnd_r_w[FRAC_W +: SMP_W];
  assign ci_w    = sc_ni_q ? (SMP_W'(0) - rnd_i_w[FRAC_W +: SMP_W]) : rnd_i_w[FRAC_W +: SMP_W];

  assign res_w.gain = sc_gain_q;
  assign res_w.re   = cr_w;
  assign res_w.im   = ci_w;

  // Clean power for write-back
  logic              pw_vld_q;
  logic [BIN_AW-1:0] pw_bin_q;
  logic [SMP_W-1:0]  pw_re_q, pw_im_q;
  logic signed [POW_W-1:0] pr2_w, pi2_w;

  always_ff @(posedge clk_i) begin
    pw_bin_q <= sc_bin_q;
    pw_re_q  <= cr_w;
    pw_im_q  <= ci_w;
  end

  assign pr2_w = $signed(pw_re_q) * $signed(pw_re_q);
  assign pi2_w = $signed(pw_im_q) * $signed(pw_im_q);

  always_ff @(posedge clk_i) begin
    sq_bin_q <= pw_bin_q;
    sq_r_q   <= pr2_w;
    sq_i_q   <= pi2_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
      pw_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
    end else begin
      sc_vld_q <= dv_vld_w;
      pw_vld_q <= sc_vld_q;
      sq_vld_q <= pw_vld_q;
    end
  end

  // Output queue
  swbg_pkg::res_t out_w;

  swbg_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (sc_vld_q),
    .push_data_i (res_w),
    .pop_i       (out_pop_w),
    .valid_o     (out_valid_o),
    .data_o      (out_w)
  );

  assign gain_o       = out_w.gain;
  assign clean_real_o = out_w.re;
  assign clean_imag_o = out_w.im;

  // Checks
  a_wb_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q |-> busy_q[sq_bin_q])
    else $error("clean power write-back to a bin not in flight");

  a_credit_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CREDIT_W'(swbg_pkg::FIFO_DEPTH))
    else $error("request credits exceed output queue depth");

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_o <= swbg_pkg::COEF_ONE))
    else $error("gain above unity");

  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (gain_o == '0)) |-> ((clean_real_o == '0) && (clean_imag_o == '0)))
    else $error("zero gain with nonzero clean bin");

endmodule

`default_nettype wire
